// ----- rtl/isra_pkg.sv -----
`timescale 1ns / 1ps
package isra_pkg;

  // Field widths of the request and result items.
  localparam int OP_W    = 3;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int SET_W   = 4;
  localparam int SLOT_W  = 6;
  localparam int ENTRY_W = 32;
  localparam int IDX_W   = 7;
  localparam int SUM_W   = 38;
  localparam int STAT_W  = 2;
  localparam int SIU_W   = 5;

  // Default sizes of the stores.
  localparam int DEF_ROWS    = 64;
  localparam int DEF_COLS    = 64;
  localparam int DEF_SETS    = 16;
  localparam int DEF_SET_LEN = 64;

  localparam int QUEUE_DEPTH = 4;

  // Operation codes of a request.
  localparam logic [OP_W-1:0] OP_WR_ENTRY  = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_MEMBER = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_LENGTH = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_TRANS  = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SET = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_COL = 2'd2;

  // Register indexes on the configuration port (word address).
  localparam logic REG_USE_TRANSLATION = 1'b0;
  localparam logic REG_SETS_IN_USE     = 1'b1;

  localparam logic [SIU_W-1:0] SETS_IN_USE_RESET = 5'd16;

  typedef enum logic [2:0] {
    K_MAT_WR,
    K_MEM_WR,
    K_LEN_WR,
    K_TR_WR,
    K_QUERY,
    K_QERR
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    column;
    logic [SET_W-1:0]    set_id;
    logic [SLOT_W-1:0]   slot;
    logic [ENTRY_W-1:0]  entry_value;
    logic [IDX_W-1:0]    index_value;
    logic [STAT_W-1:0]   status;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN
  } back_state_t;

endpackage

// ----- rtl/isra_front.sv -----
`timescale 1ns / 1ps
module isra_front #(
  parameter int ROWS    = isra_pkg::DEF_ROWS,
  parameter int COLS    = isra_pkg::DEF_COLS,
  parameter int SETS    = isra_pkg::DEF_SETS,
  parameter int SET_LEN = isra_pkg::DEF_SET_LEN
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [isra_pkg::OP_W-1:0]      in_operation,
  input  logic [isra_pkg::ROW_W-1:0]     in_row,
  input  logic [isra_pkg::COL_W-1:0]     in_column,
  input  logic [isra_pkg::SET_W-1:0]     in_set_id,
  input  logic [isra_pkg::SLOT_W-1:0]    in_slot,
  input  logic [isra_pkg::ENTRY_W-1:0]   in_entry_value,
  input  logic [isra_pkg::IDX_W-1:0]     in_index_value,
  input  logic [isra_pkg::SIU_W-1:0]     sets_in_use,
  output logic                           push_valid,
  output isra_pkg::item_t                push_item,
  input  logic                           q_full
);

  logic            fr_valid_r, fr_valid_nxt;
  isra_pkg::item_t fr_item_r;
  isra_pkg::item_t cls;
  logic            keep;
  logic            accept;

  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  // Writes that fall outside the stores do nothing, so they are dropped here.
  // Queries that fail the set or row check go on marked with their status.
  always_comb begin
    cls.kind        = isra_pkg::K_QUERY;
    cls.row         = in_row;
    cls.column      = in_column;
    cls.set_id      = in_set_id;
    cls.slot        = in_slot;
    cls.entry_value = in_entry_value;
    cls.index_value = in_index_value;
    cls.status      = isra_pkg::ST_OK;
    keep            = 1'b0;
    unique case (in_operation)
      isra_pkg::OP_WR_ENTRY: begin
        cls.kind = isra_pkg::K_MAT_WR;
        keep     = (32'(in_row) < ROWS) && (32'(in_column) < COLS);
      end
      isra_pkg::OP_WR_MEMBER: begin
        cls.kind = isra_pkg::K_MEM_WR;
        keep     = (32'(in_set_id) < SETS) && (32'(in_slot) < SET_LEN);
      end
      isra_pkg::OP_WR_LENGTH: begin
        cls.kind = isra_pkg::K_LEN_WR;
        keep     = 32'(in_set_id) < SETS;
      end
      isra_pkg::OP_WR_TRANS: begin
        cls.kind = isra_pkg::K_TR_WR;
        keep     = 32'(in_slot) < COLS;
      end
      isra_pkg::OP_QUERY: begin
        keep = 1'b1;
        if (({1'b0, in_set_id} >= sets_in_use) || (32'(in_set_id) >= SETS)) begin
          cls.kind   = isra_pkg::K_QERR;
          cls.status = isra_pkg::ST_BAD_SET;
        end else if (32'(in_row) >= ROWS) begin
          cls.kind   = isra_pkg::K_QERR;
          cls.status = isra_pkg::ST_BAD_COL;
        end else begin
          cls.kind = isra_pkg::K_QUERY;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  assign fr_valid_nxt = accept ? keep : (fr_valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= cls;
    end
  end

  assign push_valid = fr_valid_r;
  assign push_item  = fr_item_r;

endmodule

// ----- rtl/isra_queue.sv -----
`timescale 1ns / 1ps
module isra_queue #(
  parameter int DEPTH = isra_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  isra_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  output isra_pkg::item_t head,
  input  logic            pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  isra_pkg::item_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = count_r == CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slots[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/isra_back.sv -----
`timescale 1ns / 1ps
module isra_back #(
  parameter int ROWS    = isra_pkg::DEF_ROWS,
  parameter int COLS    = isra_pkg::DEF_COLS,
  parameter int SETS    = isra_pkg::DEF_SETS,
  parameter int SET_LEN = isra_pkg::DEF_SET_LEN
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 head_valid,
  input  isra_pkg::item_t                      head,
  output logic                                 pop,
  input  logic                                 use_translation,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [isra_pkg::SUM_W-1:0]    out_row_sum,
  output logic [isra_pkg::ROW_W-1:0]           out_query_row,
  output logic [isra_pkg::STAT_W-1:0]          out_status
);

  localparam int MAW = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
  localparam int MBW = (SETS * SET_LEN > 1) ? $clog2(SETS * SET_LEN) : 1;
  localparam int TW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int SW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int KW  = $clog2(SET_LEN + 1);
  localparam int EXT = isra_pkg::SUM_W - isra_pkg::ENTRY_W;

  // Stores.
  logic [isra_pkg::ENTRY_W-1:0] mat_mem    [ROWS * COLS];
  logic [isra_pkg::IDX_W-1:0]   member_mem [SETS * SET_LEN];
  logic [isra_pkg::IDX_W-1:0]   trans_mem  [COLS];
  logic [KW-1:0]                len_mem    [SETS];
  logic [SETS-1:0]              len_valid_r;

  isra_pkg::back_state_t state_r, state_nxt;

  // Query context.
  logic [isra_pkg::ROW_W-1:0]   q_row_r;
  logic [MAW-1:0]               row_base_r;
  logic [MBW-1:0]               set_base_r;
  logic [KW-1:0]                len_rd_r;
  logic                         len_ok_r;
  logic [KW-1:0]                len_eff;
  logic [KW-1:0]                k_r;
  logic signed [isra_pkg::SUM_W-1:0] sum_r;
  logic                         err_r;

  // Walk pipeline: member read, translation read, matrix read, accumulate.
  logic                         p1_v_r, p2_v_r, p3_v_r;
  logic [isra_pkg::IDX_W-1:0]   member_rd_r;
  logic [isra_pkg::IDX_W-1:0]   member_d_r;
  logic [isra_pkg::IDX_W-1:0]   trans_rd_r;
  logic [isra_pkg::ENTRY_W-1:0] mat_rd_r;
  logic [isra_pkg::IDX_W-1:0]   col_sel;
  logic                         col_bad;
  logic [MAW-1:0]               mat_raddr;
  logic [MAW-1:0]               mat_waddr;
  logic [MBW-1:0]               mem_raddr;
  logic [MBW-1:0]               mem_waddr;
  logic [SW-1:0]                set_idx;
  logic [KW-1:0]                len_sat;
  logic                         pipe_empty;

  // Control.
  logic out_free;
  logic issue;
  logic start;
  logic load_qerr;
  logic load_res;
  logic go_drain;
  logic mat_we, mem_we, len_we, tr_we;

  logic out_valid_r, out_valid_nxt;
  logic signed [isra_pkg::SUM_W-1:0]  out_sum_r;
  logic [isra_pkg::ROW_W-1:0]         out_row_r;
  logic [isra_pkg::STAT_W-1:0]        out_status_r;

  assign out_free   = !out_valid_r || !out_stall;
  assign len_eff    = len_ok_r ? len_rd_r : '0;
  assign pipe_empty = !p1_v_r && !p2_v_r && !p3_v_r;
  assign go_drain   = !issue || ((k_r + KW'(1)) == len_eff);
  assign set_idx    = SW'(head.set_id);
  assign len_sat    = (32'(head.index_value) > SET_LEN) ? KW'(SET_LEN) : KW'(head.index_value);
  assign mat_waddr  = MAW'(32'(head.row) * COLS + 32'(head.column));
  assign mem_waddr  = MBW'(32'(head.set_id) * SET_LEN + 32'(head.slot));
  assign mem_raddr  = set_base_r + MBW'(k_r);

  // A member at or beyond the matrix cannot be translated, so it fails on its own.
  always_comb begin
    col_sel = use_translation ? trans_rd_r : member_d_r;
    col_bad = (32'(member_d_r) >= COLS) ||
              (use_translation && (32'(trans_rd_r) >= COLS));
    mat_raddr = col_bad ? row_base_r : row_base_r + MAW'(col_sel);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isra_pkg::BK_IDLE: begin
        if (start) begin
          state_nxt = isra_pkg::BK_WALK;
        end
      end
      isra_pkg::BK_WALK: begin
        if (go_drain) begin
          state_nxt = isra_pkg::BK_DRAIN;
        end
      end
      isra_pkg::BK_DRAIN: begin
        if (load_res) begin
          state_nxt = isra_pkg::BK_IDLE;
        end
      end
      default: state_nxt = isra_pkg::BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop       = 1'b0;
    start     = 1'b0;
    load_qerr = 1'b0;
    load_res  = 1'b0;
    issue     = 1'b0;
    unique case (state_r)
      isra_pkg::BK_IDLE: begin
        if (head_valid) begin
          if (head.kind == isra_pkg::K_QERR) begin
            pop       = out_free;
            load_qerr = out_free;
          end else begin
            pop   = 1'b1;
            start = head.kind == isra_pkg::K_QUERY;
          end
        end
      end
      isra_pkg::BK_WALK: begin
        issue = k_r < len_eff;
      end
      isra_pkg::BK_DRAIN: begin
        load_res = pipe_empty && out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign mat_we = pop && (head.kind == isra_pkg::K_MAT_WR);
  assign mem_we = pop && (head.kind == isra_pkg::K_MEM_WR);
  assign len_we = pop && (head.kind == isra_pkg::K_LEN_WR);
  assign tr_we  = pop && (head.kind == isra_pkg::K_TR_WR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= isra_pkg::BK_IDLE;
      len_valid_r <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (len_we) begin
        len_valid_r[set_idx] <= 1'b1;
      end
      p1_v_r      <= issue;
      p2_v_r      <= p1_v_r;
      p3_v_r      <= p2_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (mat_we) begin
      mat_mem[mat_waddr] <= head.entry_value;
    end
    if (p2_v_r) begin
      mat_rd_r <= mat_mem[mat_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      member_mem[mem_waddr] <= head.index_value;
    end
    if (issue) begin
      member_rd_r <= member_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tr_we) begin
      trans_mem[TW'(head.slot)] <= head.index_value;
    end
    if (p1_v_r) begin
      trans_rd_r <= trans_mem[TW'(member_rd_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[set_idx] <= len_sat;
    end
    if (start) begin
      len_rd_r <= len_mem[set_idx];
    end
  end

  // Query context and accumulation.
  always_ff @(posedge clk) begin
    if (start) begin
      len_ok_r   <= len_valid_r[set_idx];
      q_row_r    <= head.row;
      row_base_r <= MAW'(32'(head.row) * COLS);
      set_base_r <= MBW'(32'(head.set_id) * SET_LEN);
      k_r        <= '0;
      sum_r      <= '0;
      err_r      <= 1'b0;
    end else begin
      if (issue) begin
        k_r <= k_r + KW'(1);
      end
      if (p2_v_r && col_bad) begin
        err_r <= 1'b1;
      end
      if (p3_v_r) begin
        sum_r <= sum_r + $signed({{EXT{mat_rd_r[isra_pkg::ENTRY_W-1]}}, mat_rd_r});
      end
    end
    if (p1_v_r) begin
      member_d_r <= member_rd_r;
    end
  end

  // Result register.
  assign out_valid_nxt = (load_qerr || load_res) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (load_qerr) begin
      out_sum_r    <= '0;
      out_row_r    <= head.row;
      out_status_r <= head.status;
    end else if (load_res) begin
      out_sum_r    <= err_r ? '0 : sum_r;
      out_row_r    <= q_row_r;
      out_status_r <= err_r ? isra_pkg::ST_BAD_COL : isra_pkg::ST_OK;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_sum   = out_sum_r;
  assign out_query_row = out_row_r;
  assign out_status    = out_status_r;

endmodule

// ----- rtl/indexed_set_row_accumulate_core.sv -----
// Indexed set row accumulator. Requests load a Q16.16 matrix, the member
// columns and lengths of up to SETS column sets, and a column translation
// table; a query request returns the sum of one matrix row over the members
// of one set (each member mapped through the translation table when
// use_translation is 1), with status 1 for a set at or above sets_in_use or
// SETS, status 2 for a row or column outside the matrix; the sum is then zero.
// Requests enter a classifying register and a four-entry queue, so the input
// keeps flowing while a query runs or a result waits to be taken, until the
// queue fills. Write requests leave the queue at once in the execution unit,
// rejected queries as soon as the result register is free. A query walks the
// members of its set while the next request waits; the single read port of
// the matrix memory delivers one member's entry per cycle, behind a
// three-stage member, translation and matrix read pipe.
// Stores other than the set lengths power up undefined and must be written
// before a query uses them; the set lengths reset to empty.
`timescale 1ns / 1ps
module indexed_set_row_accumulate_core #(
  parameter int ROWS    = isra_pkg::DEF_ROWS,
  parameter int COLS    = isra_pkg::DEF_COLS,
  parameter int SETS    = isra_pkg::DEF_SETS,
  parameter int SET_LEN = isra_pkg::DEF_SET_LEN
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [isra_pkg::OP_W-1:0]            in_operation,
  input  logic [isra_pkg::ROW_W-1:0]           in_row,
  input  logic [isra_pkg::COL_W-1:0]           in_column,
  input  logic [isra_pkg::SET_W-1:0]           in_set_id,
  input  logic [isra_pkg::SLOT_W-1:0]          in_slot,
  input  logic signed [isra_pkg::ENTRY_W-1:0]  in_entry_value,
  input  logic [isra_pkg::IDX_W-1:0]           in_index_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [isra_pkg::SUM_W-1:0]    out_row_sum,
  output logic [isra_pkg::ROW_W-1:0]           out_query_row,
  output logic [isra_pkg::STAT_W-1:0]          out_status,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic                       use_trans_r, use_trans_nxt;
  logic [isra_pkg::SIU_W-1:0] sets_in_use_r, sets_in_use_nxt;
  logic                       cfg_wr;

  logic            q_push;
  isra_pkg::item_t q_push_item;
  logic            q_full;
  logic            q_head_valid;
  isra_pkg::item_t q_head;
  logic            q_pop;

  // Configuration registers, word addressed.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    use_trans_nxt   = use_trans_r;
    sets_in_use_nxt = sets_in_use_r;
    if (cfg_wr) begin
      if (paddr[2] == isra_pkg::REG_USE_TRANSLATION) begin
        use_trans_nxt = pwdata[0];
      end else begin
        sets_in_use_nxt = pwdata[isra_pkg::SIU_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_trans_r   <= 1'b0;
      sets_in_use_r <= isra_pkg::SETS_IN_USE_RESET;
    end else begin
      use_trans_r   <= use_trans_nxt;
      sets_in_use_r <= sets_in_use_nxt;
    end
  end

  assign prdata = (paddr[2] == isra_pkg::REG_SETS_IN_USE) ?
                  {{(32 - isra_pkg::SIU_W){1'b0}}, sets_in_use_r} :
                  {31'b0, use_trans_r};

  isra_front #(
    .ROWS    (ROWS),
    .COLS    (COLS),
    .SETS    (SETS),
    .SET_LEN (SET_LEN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_set_id      (in_set_id),
    .in_slot        (in_slot),
    .in_entry_value (in_entry_value),
    .in_index_value (in_index_value),
    .sets_in_use    (sets_in_use_r),
    .push_valid     (q_push),
    .push_item      (q_push_item),
    .q_full         (q_full)
  );

  isra_queue #(
    .DEPTH (isra_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  isra_back #(
    .ROWS    (ROWS),
    .COLS    (COLS),
    .SETS    (SETS),
    .SET_LEN (SET_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head            (q_head),
    .pop             (q_pop),
    .use_translation (use_trans_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_sum     (out_row_sum),
    .out_query_row   (out_query_row),
    .out_status      (out_status)
  );

`ifndef SYNTHESIS
  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head_valid)
    else $error("execution unit popped an empty queue");

  a_failed_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != isra_pkg::ST_OK)) |-> (out_row_sum == '0))
    else $error("failed query carries a nonzero sum");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (q_push && q_full))
    else $error("input stalled without a blocked request");
`endif

endmodule
